[rtl/assert_macros.svh]
// Assertion macros shared by the transmitter modules.
// Each macro samples on the rising edge of aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while the block is out of reset.
`define SAWFT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define SAWFT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/sawft_pkg.sv]
// ----------------------------------------------------------------------------
// sawft_pkg
// Shared constants, codes and controller/datapath interface types of the
// stop-and-wait frame transmitter.
// ----------------------------------------------------------------------------
package sawft_pkg;

    localparam int PAYLOAD_MAX = 32;
    localparam int ADDR_W      = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);

    // Input actions.
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_RSP   = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    // Result events.
    localparam logic [2:0] EV_FIRST    = 3'd0;
    localparam logic [2:0] EV_RESEND   = 3'd1;
    localparam logic [2:0] EV_ACK      = 3'd2;
    localparam logic [2:0] EV_GIVEUP   = 3'd3;
    localparam logic [2:0] EV_OVERFLOW = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_ADDRESS = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_RETRIES = 2'd2;

    // Frame and response codes.
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] CTRL_SEQ0 = 8'h00;
    localparam logic [7:0] CTRL_SEQ1 = 8'h40;
    localparam logic [7:0] RR_SEQ0   = 8'h05;
    localparam logic [7:0] RR_SEQ1   = 8'h85;
    localparam logic [7:0] REJ_SEQ0  = 8'h01;
    localparam logic [7:0] REJ_SEQ1  = 8'h81;

    // Frame byte selection.
    localparam logic [2:0] SEL_FLAG  = 3'd0;
    localparam logic [2:0] SEL_ADDR  = 3'd1;
    localparam logic [2:0] SEL_CTRL  = 3'd2;
    localparam logic [2:0] SEL_HCS   = 3'd3;
    localparam logic [2:0] SEL_DATA  = 3'd4;
    localparam logic [2:0] SEL_CHECK = 3'd5;

    typedef struct packed {
        logic       load;
        logic       ack;
        logic       retry_clr;
        logic       timeout;
        logic       tick_inc;
        logic       frame_start;
        logic       frame_resend;
        logic       ptr_inc;
        logic       out_load;
        logic       out_event;
        logic [2:0] event_code;
        logic [2:0] byte_sel;
        logic       out_last;
    } sawft_cmd_t;

    typedef struct packed {
        logic out_free;
        logic full;
        logic buf_empty;
        logic is_rr;
        logic is_rej;
        logic tick_hit;
        logic give_up;
        logic last_data;
    } sawft_stat_t;

endpackage

[rtl/sawft_ctrl.sv]
// ----------------------------------------------------------------------------
// sawft_ctrl
// Controller: decodes accepted items and sequences the bytes of a frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sawft_ctrl
    import sawft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  sawft_stat_t stat,
    output sawft_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WAIT   = 4'd1;
    localparam logic [3:0] ST_F_FLAG = 4'd2;
    localparam logic [3:0] ST_F_ADDR = 4'd3;
    localparam logic [3:0] ST_F_CTRL = 4'd4;
    localparam logic [3:0] ST_F_HCS  = 4'd5;
    localparam logic [3:0] ST_F_DATA = 4'd6;
    localparam logic [3:0] ST_F_CHK  = 4'd7;
    localparam logic [3:0] ST_F_END  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign s_ready = ((state_reg == ST_IDLE) || (state_reg == ST_WAIT)) && stat.out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        ACT_LOAD: begin
                            if (stat.full) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_event  = 1'b1;
                                cmd.event_code = EV_OVERFLOW;
                            end else begin
                                cmd.load = 1'b1;
                            end
                        end
                        ACT_START: begin
                            cmd.frame_start = 1'b1;
                            cmd.retry_clr   = 1'b1;
                            state_next      = ST_F_FLAG;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WAIT: begin
                if (accept) begin
                    case (s_action)
                        ACT_RSP: begin
                            if (stat.is_rr) begin
                                cmd.ack        = 1'b1;
                                cmd.out_load   = 1'b1;
                                cmd.out_event  = 1'b1;
                                cmd.event_code = EV_ACK;
                                state_next     = ST_IDLE;
                            end else if (stat.is_rej) begin
                                cmd.frame_start  = 1'b1;
                                cmd.frame_resend = 1'b1;
                                state_next       = ST_F_FLAG;
                            end
                        end
                        ACT_TICK: begin
                            if (stat.tick_hit) begin
                                cmd.timeout = 1'b1;
                                if (stat.give_up) begin
                                    cmd.out_load   = 1'b1;
                                    cmd.out_event  = 1'b1;
                                    cmd.event_code = EV_GIVEUP;
                                    state_next     = ST_IDLE;
                                end else begin
                                    cmd.frame_start  = 1'b1;
                                    cmd.frame_resend = 1'b1;
                                    state_next       = ST_F_FLAG;
                                end
                            end else begin
                                cmd.tick_inc = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_F_FLAG: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.byte_sel = SEL_FLAG;
                    state_next   = ST_F_ADDR;
                end
            end
            ST_F_ADDR: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.byte_sel = SEL_ADDR;
                    state_next   = ST_F_CTRL;
                end
            end
            ST_F_CTRL: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.byte_sel = SEL_CTRL;
                    state_next   = ST_F_HCS;
                end
            end
            ST_F_HCS: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.byte_sel = SEL_HCS;
                    state_next   = stat.buf_empty ? ST_F_CHK : ST_F_DATA;
                end
            end
            ST_F_DATA: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.byte_sel = SEL_DATA;
                    cmd.ptr_inc  = 1'b1;
                    if (stat.last_data) begin
                        state_next = ST_F_CHK;
                    end
                end
            end
            ST_F_CHK: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.byte_sel = SEL_CHECK;
                    state_next   = ST_F_END;
                end
            end
            ST_F_END: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.byte_sel = SEL_FLAG;
                    cmd.out_last = 1'b1;
                    state_next   = ST_WAIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SAWFT_ASSERT(a_start_opens_frame, (accept && (state_reg == ST_IDLE) && (s_action == ACT_START)) |=> (state_reg == ST_F_FLAG), "start in idle did not open a frame")
    `SAWFT_ASSERT(a_end_goes_wait, (state_reg == ST_F_END && stat.out_free) |=> (state_reg == ST_WAIT), "closing flag did not lead to waiting")
    `SAWFT_ASSERT(a_load_only_idle, cmd.load |-> ((state_reg == ST_IDLE) && !stat.full), "payload written outside idle or into a full buffer")

endmodule

[rtl/sawft_dp.sv]
// ----------------------------------------------------------------------------
// sawft_dp
// Datapath: payload buffer, check byte, sequence, retry and tick counters,
// configuration registers and the result output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sawft_dp
    import sawft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_last,
    output logic [2:0]  m_event_res,
    input  sawft_cmd_t  cmd,
    output sawft_stat_t stat
);

    logic [7:0]        mem [PAYLOAD_MAX];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [LEN_W-1:0]  len_reg;
    logic [7:0]        check_reg;
    logic              seq_reg;
    logic [2:0]        retry_reg;
    logic [2:0]        retry_plus;
    logic [15:0]       tick_reg;
    logic [15:0]       tick_plus;
    logic [7:0]        address_reg;
    logic [15:0]       timeout_reg;
    logic [2:0]        max_retries_reg;
    logic [2:0]        ev_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_bvalid_reg;
    logic              out_last_reg;
    logic [2:0]        out_event_reg;
    logic [7:0]        ctrl_byte;
    logic [7:0]        frame_byte;

    assign cfg_ready = 1'b1;

    assign ctrl_byte  = seq_reg ? CTRL_SEQ1 : CTRL_SEQ0;
    assign tick_plus  = tick_reg + 16'd1;
    assign retry_plus = retry_reg + 3'd1;

    assign stat.out_free  = !out_valid_reg || m_ready;
    assign stat.full      = (len_reg == LEN_W'(PAYLOAD_MAX));
    assign stat.buf_empty = (len_reg == '0);
    assign stat.is_rr     = (s_data_byte == (seq_reg ? RR_SEQ0 : RR_SEQ1));
    assign stat.is_rej    = (s_data_byte == (seq_reg ? REJ_SEQ1 : REJ_SEQ0));
    assign stat.tick_hit  = (tick_plus >= timeout_reg);
    assign stat.give_up   = (retry_plus >= max_retries_reg);
    assign stat.last_data = ((LEN_W'(ptr_reg) + LEN_W'(1)) == len_reg);

    always_comb begin
        if (cmd.frame_start) begin
            ptr_next = '0;
        end else if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + ADDR_W'(1);
        end else begin
            ptr_next = ptr_reg;
        end
    end

    always_comb begin
        case (cmd.byte_sel)
            SEL_FLAG:  frame_byte = FLAG_BYTE;
            SEL_ADDR:  frame_byte = address_reg;
            SEL_CTRL:  frame_byte = ctrl_byte;
            SEL_HCS:   frame_byte = address_reg ^ ctrl_byte;
            SEL_DATA:  frame_byte = rd_data_reg;
            SEL_CHECK: frame_byte = check_reg;
            default:   frame_byte = FLAG_BYTE;
        endcase
    end

    // The read port follows the payload pointer, so the byte at the pointer
    // is always ready in rd_data_reg when the frame reaches it.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mem[len_reg[ADDR_W-1:0]] <= s_data_byte;
        end
        rd_data_reg <= mem[ptr_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.frame_start) begin
            ev_reg <= cmd.frame_resend ? EV_RESEND : EV_FIRST;
        end
        if (cmd.out_load) begin
            if (cmd.out_event) begin
                out_byte_reg   <= 8'h00;
                out_bvalid_reg <= 1'b0;
                out_last_reg   <= 1'b1;
                out_event_reg  <= cmd.event_code;
            end else begin
                out_byte_reg   <= frame_byte;
                out_bvalid_reg <= 1'b1;
                out_last_reg   <= cmd.out_last;
                out_event_reg  <= ev_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg         <= '0;
            len_reg         <= '0;
            check_reg       <= 8'h00;
            seq_reg         <= 1'b0;
            retry_reg       <= 3'd0;
            tick_reg        <= 16'd0;
            address_reg     <= 8'd3;
            timeout_reg     <= 16'd3;
            max_retries_reg <= 3'd3;
            out_valid_reg   <= 1'b0;
        end else begin
            ptr_reg <= ptr_next;

            if (cmd.ack) begin
                len_reg   <= '0;
                check_reg <= 8'h00;
                seq_reg   <= ~seq_reg;
            end else if (cmd.load) begin
                len_reg   <= len_reg + LEN_W'(1);
                check_reg <= check_reg ^ s_data_byte;
            end

            if (cmd.ack || cmd.retry_clr) begin
                retry_reg <= 3'd0;
            end else if (cmd.timeout) begin
                retry_reg <= retry_plus;
            end

            if (cmd.ack || cmd.timeout || cmd.frame_start) begin
                tick_reg <= 16'd0;
            end else if (cmd.tick_inc) begin
                tick_reg <= tick_plus;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ADDRESS: address_reg     <= cfg_data[7:0];
                    REG_TIMEOUT: timeout_reg     <= cfg_data;
                    REG_RETRIES: max_retries_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end

            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_byte_valid = out_bvalid_reg;
    assign m_last       = out_last_reg;
    assign m_event_res  = out_event_reg;

    `SAWFT_ASSERT(a_len_bounded, len_reg <= LEN_W'(PAYLOAD_MAX), "payload length beyond buffer size")
    `SAWFT_ASSERT(a_ack_clears, cmd.ack |=> ((len_reg == '0) && (check_reg == 8'h00)), "acknowledge did not clear the buffer")
    `SAWFT_ASSERT(a_load_grows, cmd.load |=> (len_reg == LEN_W'($past(len_reg) + LEN_W'(1))), "load did not advance the length")

endmodule

[rtl/stop_and_wait_frame_transmitter_core.sv]
// ----------------------------------------------------------------------------
// stop_and_wait_frame_transmitter_core
// Stop-and-wait frame sender with retransmission on reject and timeout.
// ----------------------------------------------------------------------------
// A load, response or tick beat is accepted whenever the block is idle or
// waiting and the result register is free or being emptied in the same cycle.
// A start, a matching reject or a timeout that resends streams the frame
// through the result register at one byte per cycle while that register is
// free or being emptied, beginning in the flag state entered after the beat
// is taken: flag, address, control, header check, payload bytes, check byte
// and closing flag. No input beat is accepted until the closing flag is in
// that register, and a result stall holds the frame at its current byte.
// Payload bytes are read from a 32-entry buffer with a registered read port
// that follows the frame's payload pointer. Configuration writes are taken in
// any cycle and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module stop_and_wait_frame_transmitter_core
    import sawft_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_last,
    output logic [2:0]  m_event_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    sawft_cmd_t  cmd;
    sawft_stat_t stat;

    sawft_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .stat     (stat),
        .cmd      (cmd)
    );

    sawft_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_data_byte  (s_data_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_last       (m_last),
        .m_event_res  (m_event_res),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
